// ===== design/dws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dws_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TAG_W       = 8;
  localparam int WEIGHT_W    = 16;
  localparam int TOTAL_W     = 22;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;    // insert new_e at its sorted place
    logic   shl;    // shift every cell one place toward the output
    entry_t new_e;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/dws_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dws_in_if;
  logic                         valid;
  logic                         ready;
  logic [dws_pkg::TAG_W-1:0]    entry_tag;
  logic [dws_pkg::WEIGHT_W-1:0] entry_weight;
  logic                         last_entry;

  modport source (output valid, entry_tag, entry_weight, last_entry, input ready);
  modport sink (input valid, entry_tag, entry_weight, last_entry, output ready);
endinterface

`default_nettype wire

// ===== design/dws_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dws_out_if;
  logic                         valid;
  logic                         ready;
  logic [dws_pkg::TAG_W-1:0]    sorted_tag;
  logic [dws_pkg::WEIGHT_W-1:0] sorted_weight;
  logic [dws_pkg::TOTAL_W-1:0]  weight_total;
  logic                         entries_dropped;
  logic                         last_result;

  modport source (output valid, sorted_tag, sorted_weight, weight_total, entries_dropped,
                  last_result, input ready);
  modport sink (input valid, sorted_tag, sorted_weight, weight_total, entries_dropped,
                last_result, output ready);
endinterface

`default_nettype wire

// ===== design/dws_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dws_cell (
  input  wire logic              clk,
  input  wire dws_pkg::cell_ctl_t ctl,
  input  wire logic              valid,
  input  wire dws_pkg::entry_t   left_e,
  input  wire logic              left_keep,
  input  wire dws_pkg::entry_t   right_e,
  output dws_pkg::entry_t        held,
  output logic                   keep
);

  dws_pkg::entry_t entry_r;
  dws_pkg::entry_t entry_nxt;

  // A held entry of equal weight stays ahead of the new one, which keeps the
  // order stable. Since the chain is sorted, keep is true on a prefix only.
  assign keep = valid && (entry_r.weight >= ctl.new_e.weight);
  assign held = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shl) begin
      entry_nxt = right_e;
    end else if (ctl.ins && !keep) begin
      entry_nxt = left_keep ? ctl.new_e : left_e;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== design/descending_weight_sorter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// in_ch     sink       entry_tag[7:0], entry_weight[15:0], last_entry
// out_ch    source     sorted_tag[7:0], sorted_weight[15:0], weight_total[21:0],
//                      entries_dropped, last_result
//
// Entries load at one per cycle; each is inserted into its sorted place in the
// cell chain in the cycle it is accepted, or dropped and flagged if the chain is
// full. After the marked entry, the list drains from the head cell at one result
// per cycle while the output is ready. Input is held off while a list drains.
// Reset is synchronous and active low; it empties the chain. Output stalls
// freeze the drain without losing a result.

module descending_weight_sorter_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  dws_in_if.sink    in_ch,
  dws_out_if.source out_ch
);

  localparam int N = dws_pkg::MAX_ENTRIES;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                       state_r, state_nxt;
  logic [dws_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [dws_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic                         ovf_r, ovf_nxt;

  logic                         out_valid_r, out_valid_nxt;
  dws_pkg::entry_t              out_e_r, out_e_nxt;
  logic [dws_pkg::TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic                         out_last_r, out_last_nxt;

  dws_pkg::cell_ctl_t           ctl;
  dws_pkg::entry_t              cell_e [N];
  logic [N-1:0]                 cell_keep;
  logic [N-1:0]                 cell_valid;
  logic                         in_xfer;
  logic                         load_out;
  logic                         has_room;
  logic                         chain_sorted;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign has_room    = (count_r < dws_pkg::CNT_W'(N));
  assign load_out    = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);

  assign ctl.ins          = in_xfer && has_room;
  assign ctl.shl          = load_out;
  assign ctl.new_e.tag    = in_ch.entry_tag;
  assign ctl.new_e.weight = in_ch.entry_weight;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dws_pkg::entry_t left_e;
    dws_pkg::entry_t right_e;
    logic            left_keep;

    assign cell_valid[i] = (dws_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_e    = '0;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_e    = cell_e[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_e[i+1];
    end

    dws_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (cell_valid[i]),
      .left_e    (left_e),
      .left_keep (left_keep),
      .right_e   (right_e),
      .held      (cell_e[i]),
      .keep      (cell_keep[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_e_nxt     = out_e_r;
    out_total_nxt = out_total_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (has_room) begin
            count_nxt = count_r + 1'b1;
            total_nxt = total_r + dws_pkg::TOTAL_W'(in_ch.entry_weight);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_entry) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_e_nxt     = cell_e[0];
          out_total_nxt = total_r;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = (count_r == dws_pkg::CNT_W'(1));
          count_nxt     = count_r - 1'b1;
          if (count_r == dws_pkg::CNT_W'(1)) begin
            // The final result goes into the output register; start a new list.
            state_nxt = ST_LOAD;
            total_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_e_r     <= out_e_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sorted_tag      = out_e_r.tag;
  assign out_ch.sorted_weight   = out_e_r.weight;
  assign out_ch.weight_total    = out_total_r;
  assign out_ch.entries_dropped = out_ovf_r;
  assign out_ch.last_result     = out_last_r;

  always_comb begin
    chain_sorted = 1'b1;
    for (int i = 0; i < N - 1; i++) begin
      if (cell_valid[i+1] && (cell_e[i].weight < cell_e[i+1].weight)) begin
        chain_sorted = 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dws_pkg::CNT_W'(N))
    else $error("entry count exceeds the chain length");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("draining an empty chain");

  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && count_r == dws_pkg::CNT_W'(1)) |=>
      (state_r == ST_LOAD && count_r == '0 && out_last_r && total_r == '0))
    else $error("list did not close after its final result");

  a_chain_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    chain_sorted)
    else $error("cell chain is out of descending order");

endmodule

`default_nettype wire

// ===== test/descending_weight_sorter_unit_tb.sv =====
`timescale 1ns / 1ps

module descending_weight_sorter_unit_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;

  typedef enum {W_FULL, W_TIES, W_MAX, W_EDGE} weight_mode_t;

  typedef struct {
    dws_pkg::entry_t e;
    logic            mark;
    int unsigned     gap;
    bit              wait_idle;
  } feed_item_t;

  typedef struct {
    logic [dws_pkg::TAG_W-1:0]    tag;
    logic [dws_pkg::WEIGHT_W-1:0] weight;
    logic [dws_pkg::TOTAL_W-1:0]  total;
    logic                         dropped;
    logic                         last;
  } sorted_result_t;

  logic clk;
  logic rst_n;

  dws_in_if  in_ch();
  dws_out_if out_ch();

  descending_weight_sorter_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  feed_item_t     entry_feed_q[$];
  sorted_result_t sorted_results_q[$];

  // Model of the list being collected, kept in sorted order as entries arrive.
  dws_pkg::entry_t             list_store[$];
  logic [dws_pkg::TOTAL_W-1:0] list_total;
  bit                          list_overflow;

  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned lists_done;
  int unsigned overflow_lists;
  int unsigned error_count;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               sorted_results_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Equal weights keep arrival order: a new entry goes behind every entry
  // whose weight is not smaller.
  task automatic take_entry(input dws_pkg::entry_t e, input logic mark);
    int pos;
    sorted_result_t r;
    if (list_store.size() < dws_pkg::MAX_ENTRIES) begin
      pos = list_store.size();
      while (pos > 0 && list_store[pos-1].weight < e.weight) pos--;
      list_store.insert(pos, e);
      list_total = list_total + dws_pkg::TOTAL_W'(e.weight);
    end else begin
      list_overflow = 1'b1;
    end
    if (mark) begin
      foreach (list_store[k]) begin
        r.tag     = list_store[k].tag;
        r.weight  = list_store[k].weight;
        r.total   = list_total;
        r.dropped = list_overflow;
        r.last    = (k == list_store.size() - 1);
        sorted_results_q.push_back(r);
      end
      lists_done++;
      if (list_overflow) overflow_lists++;
      list_store.delete();
      list_total    = '0;
      list_overflow = 1'b0;
    end
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_entry(input logic [dws_pkg::TAG_W-1:0] tag,
                           input logic [dws_pkg::WEIGHT_W-1:0] weight,
                           input logic mark, input bit calm, input bit wait_idle);
    feed_item_t it;
    it.e.tag     = tag;
    it.e.weight  = weight;
    it.mark      = mark;
    it.gap       = pick_gap(calm);
    it.wait_idle = wait_idle;
    entry_feed_q.push_back(it);
    items_queued++;
  endtask

  function automatic logic [dws_pkg::WEIGHT_W-1:0] pick_weight(input weight_mode_t mode);
    case (mode)
      W_TIES: return dws_pkg::WEIGHT_W'($urandom_range(0, 3));
      W_MAX:  return '1;
      W_EDGE: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 16'h8000;
          default: return 16'h0001;
        endcase
      end
      default: return dws_pkg::WEIGHT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_list(input int n, input weight_mode_t mode, input bit calm,
                            input bit wait_idle);
    for (int k = 0; k < n; k++) begin
      add_entry(dws_pkg::TAG_W'($urandom_range(0, 255)), pick_weight(mode), k == n - 1,
                calm, wait_idle && k == 0);
    end
  endtask

  // Driver: a transaction offered stays on the bus until the block takes it.
  bit          gap_armed;
  int unsigned gap_count;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_armed = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        take_entry('{tag: in_ch.entry_tag, weight: in_ch.entry_weight}, in_ch.last_entry);
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (entry_feed_q.size() > 0 && !gap_armed) begin
          gap_count = entry_feed_q[0].gap;
          gap_armed = 1'b1;
        end
        if (entry_feed_q.size() == 0 || gap_count > 0) begin
          if (gap_count > 0) gap_count--;
          in_ch.valid <= 1'b0;
        end else if (entry_feed_q[0].wait_idle && sorted_results_q.size() > 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid        <= 1'b1;
          in_ch.entry_tag    <= entry_feed_q[0].e.tag;
          in_ch.entry_weight <= entry_feed_q[0].e.weight;
          in_ch.last_entry   <= entry_feed_q[0].mark;
          void'(entry_feed_q.pop_front());
          gap_armed = 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor and receiver stalls.
  int unsigned hold_count;
  int unsigned rx_phase_count;
  bit          rx_calm;
  bit          long_hold_done;

  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sorted_results_q.size() == 0) begin
          $display("%0t: unexpected result, actual tag %0h weight %0h", $time,
                   out_ch.sorted_tag, out_ch.sorted_weight);
          error_count++;
        end else begin
          want = sorted_results_q.pop_front();
          check_field("sorted_tag", want.tag, out_ch.sorted_tag);
          check_field("sorted_weight", want.weight, out_ch.sorted_weight);
          check_field("weight_total", want.total, out_ch.weight_total);
          check_field("entries_dropped", want.dropped, out_ch.entries_dropped);
          check_field("last_result", want.last, out_ch.last_result);
        end
        results_checked++;
      end

      if (rx_phase_count == 0) begin
        rx_calm        = ($urandom_range(0, 2) == 0);
        rx_phase_count = 100;
      end else begin
        rx_phase_count--;
      end

      if (hold_count > 0) begin
        hold_count--;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_checked >= 120 && out_ch.valid) begin
        // Long stall while the sender keeps offering, so the input backs up.
        hold_count     = LONG_HOLD;
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
        hold_count = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned r;
    int          n;

    in_ch.valid        = 1'b0;
    in_ch.entry_tag    = '0;
    in_ch.entry_weight = '0;
    in_ch.last_entry   = 1'b0;
    out_ch.ready       = 1'b0;
    rst_n              = 1'b0;
    list_total         = '0;
    list_overflow      = 1'b0;

    // Single-entry lists at both extremes.
    add_entry(8'h00, 16'h0000, 1'b1, 1'b0, 1'b0);
    add_entry(8'hFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    // Ties must keep arrival order.
    add_entry(8'h01, 16'd5, 1'b0, 1'b0, 1'b0);
    add_entry(8'h02, 16'd9, 1'b0, 1'b0, 1'b0);
    add_entry(8'h03, 16'd5, 1'b0, 1'b0, 1'b0);
    add_entry(8'h04, 16'd9, 1'b1, 1'b0, 1'b0);
    // Ascending arrival, fully reversed by the sort.
    for (int k = 1; k <= 5; k++) begin
      add_entry(dws_pkg::TAG_W'(8'h10 + k), dws_pkg::WEIGHT_W'(k), k == 5, 1'b1, 1'b0);
    end
    // Already in descending order.
    for (int k = 5; k >= 1; k--) begin
      add_entry(dws_pkg::TAG_W'(8'h20 + k), dws_pkg::WEIGHT_W'(k * 1000), k == 1, 1'b0,
                1'b0);
    end
    // Mixed extremes.
    add_entry(8'hA5, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_entry(8'h5A, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_entry(8'h80, 16'h8000, 1'b0, 1'b0, 1'b0);
    add_entry(8'h7F, 16'h7FFF, 1'b0, 1'b0, 1'b0);
    add_entry(8'h01, 16'h0001, 1'b1, 1'b0, 1'b0);

    // A full store of largest weights gives the largest total; a 65th entry that
    // is marked gets dropped but still ends the list.
    queue_list(dws_pkg::MAX_ENTRIES, W_MAX, 1'b1, 1'b1);
    queue_list(dws_pkg::MAX_ENTRIES + 1, W_FULL, 1'b0, 1'b0);
    queue_list(dws_pkg::MAX_ENTRIES + 6, W_TIES, 1'b0, 1'b1);
    while (items_queued < 420) begin
      r = $urandom_range(0, 99);
      n = (r < 80) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 24)
                                                     : $urandom_range(25, dws_pkg::MAX_ENTRIES);
      queue_list(n, weight_mode_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 19) == 0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (entry_feed_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (sorted_results_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    if (sorted_results_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sorted_results_q.size());
      error_count++;
    end
    $display("Sorted %0d lists from %0d entries, %0d with dropped entries.", lists_done,
             items_accepted, overflow_lists);
    $display("Checked %0d results under random stalls on both sides.", results_checked);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
